### sv/sse_pkg.sv
// shared types and constants of the swept sine motor excitation block
`default_nettype none

package sse_pkg;

  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int SPEED_W    = 8;
  localparam int PERIOD_W   = 14;
  localparam int BUDGET_W   = 4;
  localparam int SINE_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QUO_W      = 16;
  localparam int STEP_W     = 6;
  localparam int PROD_W     = SPEED_W + SINE_W;

  // sweep constants
  localparam logic [PERIOD_W-1:0] PERIOD_STEP = 14'd1000;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX  = 14'd10000;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN     = -8'sd100;
  localparam logic signed [SPEED_W-1:0] SPEED_MAX     = 8'sd100;
  localparam logic signed [SPEED_W-1:0] SPEED_SKIP_LO = -8'sd30;
  localparam logic signed [SPEED_W-1:0] SPEED_SKIP_HI = 8'sd30;
  localparam logic signed [SPEED_W-1:0] SPEED_STEP    = 8'sd10;

  // register reset values
  localparam logic signed [SPEED_W-1:0] START_SPEED_RST  = -8'sd100;
  localparam logic [PERIOD_W-1:0]       START_PERIOD_RST = 14'd10000;
  localparam logic [BUDGET_W-1:0]       RUN_BUDGET_RST   = 4'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_SPEED  = 2'd0,
    CFG_START_PERIOD = 2'd1,
    CFG_RUN_BUDGET   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                       func;
    logic [TIME_W-1:0]          now_ms;
    logic signed [COUNT_W-1:0]  encoder_count;
  } in_item_t;

  typedef struct packed {
    logic                       record_valid;
    logic [TIME_W-1:0]          elapsed_ms;
    logic signed [SPEED_W-1:0]  speed_out;
    logic [PERIOD_W-1:0]        period_out;
    logic signed [COUNT_W-1:0]  count_out;
    logic                       drive_valid;
    logic signed [SPEED_W-1:0]  drive_value;
    logic                       count_clear;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_item_t;

  // sweep state seen by the sample path
  typedef struct packed {
    logic                      running;
    logic signed [SPEED_W-1:0] amplitude;
    logic [PERIOD_W-1:0]       period;
    logic [TIME_W-1:0]         run_start;
  } sweep_state_t;

  // what an experiment tick reports
  typedef struct packed {
    logic drive_stop;
    logic count_clear;
  } tick_rsp_t;

  typedef struct packed {
    logic                start;
    logic [TIME_W-1:0]   dividend;
    logic [PERIOD_W-1:0] divisor;
    logic [STEP_W-1:0]   steps;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [QUO_W-1:0]    quotient;
    logic [PERIOD_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

### sv/sse_if.sv
// valid/ready channel interfaces for items, results and register writes
`default_nettype none

interface sse_in_if
  import sse_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sse_out_if
  import sse_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sse_cfg_if
  import sse_pkg::*;
  ();
  logic      valid;
  logic      ready;
  cfg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/sse_sweep.sv
// run sequencer: registers, run phase, sweep stepping and run budget
`default_nettype none

module sse_sweep
  import sse_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_wr_i,
  input  wire cfg_item_t     cfg_i,
  input  wire logic          tick_i,
  input  wire logic [TIME_W-1:0] now_ms_i,
  output sweep_state_t       state_o,
  output tick_rsp_t          tick_o
);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_IDLE  = 2'd1,
    PH_RUN   = 2'd2
  } phase_e;

  phase_e                    phase_q;
  logic signed [SPEED_W-1:0] amp_q;
  logic [PERIOD_W-1:0]       per_q;
  logic [TIME_W-1:0]         start_q;
  logic [BUDGET_W-1:0]       ticks_q;
  logic signed [SPEED_W-1:0] start_speed_q;
  logic [PERIOD_W-1:0]       start_period_q;
  logic [BUDGET_W-1:0]       run_budget_q;

  logic signed [SPEED_W-1:0] amp_step;
  logic [PERIOD_W-1:0]       per_step;

  always_comb begin
    if (per_q > PERIOD_STEP) begin
      per_step = per_q - PERIOD_STEP;
      amp_step = amp_q;
    end else begin
      per_step = PERIOD_MAX;
      if (amp_q == SPEED_SKIP_LO) begin
        amp_step = SPEED_SKIP_HI;
      end else if (amp_q >= SPEED_MAX) begin
        amp_step = SPEED_MIN;
      end else begin
        amp_step = amp_q + SPEED_STEP;
      end
    end
  end

  always_comb begin
    tick_o.drive_stop  = (phase_q == PH_RUN) && (ticks_q == '0);
    tick_o.count_clear = (phase_q != PH_RUN);
  end

  assign state_o.running   = (phase_q == PH_RUN);
  assign state_o.amplitude = amp_q;
  assign state_o.period    = per_q;
  assign state_o.run_start = start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_START;
      amp_q          <= START_SPEED_RST;
      per_q          <= START_PERIOD_RST;
      start_q        <= '0;
      ticks_q        <= '0;
      start_speed_q  <= START_SPEED_RST;
      start_period_q <= START_PERIOD_RST;
      run_budget_q   <= RUN_BUDGET_RST;
    end else begin
      if (cfg_wr_i) begin
        unique case (cfg_i.index)
          CFG_START_SPEED:  start_speed_q  <= cfg_i.data[SPEED_W-1:0];
          CFG_START_PERIOD: start_period_q <= cfg_i.data[PERIOD_W-1:0];
          CFG_RUN_BUDGET:   run_budget_q   <= cfg_i.data[BUDGET_W-1:0];
          default: ;
        endcase
      end
      if (tick_i) begin
        unique case (phase_q)
          PH_RUN: begin
            if (ticks_q == '0) begin
              phase_q <= PH_IDLE;
            end else begin
              ticks_q <= ticks_q - 1'b1;
            end
          end
          PH_IDLE: begin
            amp_q   <= amp_step;
            per_q   <= per_step;
            ticks_q <= run_budget_q;
            start_q <= now_ms_i;
            phase_q <= PH_RUN;
          end
          // start phase, and the unused code behaves the same
          default: begin
            amp_q   <= start_speed_q;
            per_q   <= start_period_q;
            ticks_q <= run_budget_q;
            start_q <= now_ms_i;
            phase_q <= PH_RUN;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### sv/sse_div.sv
// restoring divider, one dividend bit per cycle, msb first
`default_nettype none

module sse_div
  import sse_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                busy_q;
  logic                done_q;
  logic [STEP_W-1:0]   cnt_q;
  logic [TIME_W-1:0]   dvd_q;
  logic [PERIOD_W-1:0] dsr_q;
  logic [PERIOD_W-1:0] rem_q;
  logic [QUO_W-1:0]    quo_q;

  logic [PERIOD_W:0]   rem_sh;
  logic [PERIOD_W:0]   rem_sub;
  logic                ge;
  logic [PERIOD_W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[TIME_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    ge      = (rem_sh >= {1'b0, dsr_q});
    // remainder stays below the divisor, so the top bit drops
    rem_nxt = ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
      rem_q <= rem_nxt;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

### sv/sse_sine_rom.sv
// sine lookup rom, q1.15, filled at elaboration, registered read
`default_nettype none

module sse_sine_rom
  import sse_pkg::*;
#(
  parameter int ENTRIES = 1024,
  parameter int AW      = 10
) (
  input  wire logic                     clk_i,
  input  wire logic [AW-1:0]            addr_i,
  output logic signed [SINE_W-1:0]      data_o
);

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned Q30One    = 64'd1073741824;
  localparam longint unsigned RoundQ30  = 64'd536870912;
  localparam longint unsigned SineMax   = 64'd32767;

  typedef logic signed [SINE_W-1:0] rom_t [ENTRIES];

  // quadrant fold, odd taylor series to x^11 in q2.30, then round to q1.15
  function automatic rom_t build_rom();
    rom_t            rom;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    for (int i = 0; i < ENTRIES; i++) begin
      quad = longint'(4 * i) / ENTRIES;
      r    = longint'(4 * i) - quad * ENTRIES;
      if (quad[0]) begin
        r = ENTRIES - r;
      end
      x  = (HalfPiQ30 * r) / ENTRIES;
      x2 = (x * x) >> 30;
      t  = Q30One;
      t  = Q30One - ((x2 * t) >> 30) / 110;
      t  = Q30One - ((x2 * t) >> 30) / 72;
      t  = Q30One - ((x2 * t) >> 30) / 42;
      t  = Q30One - ((x2 * t) >> 30) / 20;
      t  = Q30One - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      v  = (s * SineMax + RoundQ30) >> 30;
      if (v > SineMax) begin
        v = SineMax;
      end
      rom[i] = (quad >= 2) ? -SINE_W'(v) : SINE_W'(v);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic signed [SINE_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    rd_q <= SINE_ROM[addr_i];
  end

  assign data_o = rd_q;

endmodule

`default_nettype wire

### sv/swept_sine_motor_excitation.sv
// top level of the swept sine motor excitation sequencer
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   func, now_ms, encoder_count
//   out_o    out  valid/ready   record and drive fields, count_clear
//   cfg_i    in   valid/ready   register index, write data (always ready)
//
// experiment ticks and sample ticks outside a run go from accept through S_LOAD into the output register.
// a running sample tick passes S_MOD, S_SCALE, S_IDX, S_ROM, S_MUL, S_FIN and S_LOAD in order,
// paced by the bit-serial divider: one pass for elapsed mod period in S_MOD, then one step per bit of
// remainder * SINE_ENTRIES in S_IDX; with period zero both passes are skipped and it starts at S_ROM.
// one item is in work at a time, and the next is taken only after the previous one is loaded into
// the output register, which holds it while out_o stalls. reset leaves the start phase, no result.
`default_nettype none

module swept_sine_motor_excitation
  import sse_pkg::*;
#(
  parameter int SINE_ENTRIES = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sse_in_if.sink     in_i,
  sse_out_if.source  out_o,
  sse_cfg_if.sink    cfg_i
);

  localparam int IW = $clog2(SINE_ENTRIES);
  localparam int SW = PERIOD_W + $clog2(SINE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SCALE,
    S_IDX,
    S_ROM,
    S_MUL,
    S_FIN,
    S_LOAD
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_valid_d;

  out_item_t                 pend_q;
  out_item_t                 pend_d;
  out_item_t                 out_q;
  logic signed [SPEED_W-1:0] amp_q;
  logic [PERIOD_W-1:0]       per_q;
  logic [SW-1:0]             scaled_q;
  logic [IW-1:0]             idx_q;
  logic signed [PROD_W-1:0]  prod_q;

  sweep_state_t             sweep_st;
  tick_rsp_t                tick_rsp;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  logic signed [SINE_W-1:0] sine_val;

  logic                     in_acc;
  logic                     load;
  logic                     run_div;
  logic [TIME_W-1:0]        elapsed;
  logic signed [PROD_W-1:0] biased;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign load        = (state_q == S_LOAD) && (!out_valid_q || out_o.ready);
  assign elapsed     = in_i.data.now_ms - sweep_st.run_start;
  assign run_div     = in_acc && !in_i.data.func && sweep_st.running
                       && (sweep_st.period != '0);
  assign out_valid_d = load || (out_valid_q && !out_o.ready);

  sse_sweep u_sweep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_wr_i (cfg_i.valid && cfg_i.ready),
    .cfg_i    (cfg_i.data),
    .tick_i   (in_acc && in_i.data.func),
    .now_ms_i (in_i.data.now_ms),
    .state_o  (sweep_st),
    .tick_o   (tick_rsp)
  );

  // first pass: elapsed mod period; second pass: remainder * entries / period
  always_comb begin
    div_req.start = run_div || (state_q == S_SCALE);
    if (state_q == S_SCALE) begin
      div_req.dividend = {scaled_q, {(TIME_W - SW){1'b0}}};
      div_req.divisor  = per_q;
      div_req.steps    = STEP_W'(SW);
    end else begin
      div_req.dividend = elapsed;
      div_req.divisor  = sweep_st.period;
      div_req.steps    = STEP_W'(TIME_W);
    end
  end

  sse_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sse_sine_rom #(
    .ENTRIES (SINE_ENTRIES),
    .AW      (IW)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (idx_q),
    .data_o (sine_val)
  );

  // truncate toward zero on the divide by 32768
  assign biased = prod_q + (prod_q[PROD_W-1] ? PROD_W'(32767) : PROD_W'(0));

  // result fields known at accept time
  always_comb begin
    pend_d = '0;
    if (in_i.data.func) begin
      pend_d.drive_valid = tick_rsp.drive_stop;
      pend_d.count_clear = tick_rsp.count_clear;
    end else if (sweep_st.running) begin
      pend_d.record_valid = 1'b1;
      pend_d.elapsed_ms   = elapsed;
      pend_d.speed_out    = sweep_st.amplitude;
      pend_d.period_out   = sweep_st.period;
      pend_d.count_out    = in_i.data.encoder_count;
      pend_d.drive_valid  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_i.data.func || !sweep_st.running) begin
              state_q <= S_LOAD;
            end else if (sweep_st.period != '0) begin
              state_q <= S_MOD;
            end else begin
              state_q <= S_ROM;
            end
          end
        end
        S_MOD: begin
          if (div_rsp.done) begin
            state_q <= S_SCALE;
          end
        end
        S_SCALE: state_q <= S_IDX;
        S_IDX: begin
          if (div_rsp.done) begin
            state_q <= S_ROM;
          end
        end
        S_ROM: state_q <= S_MUL;
        S_MUL: state_q <= S_FIN;
        S_FIN: state_q <= S_LOAD;
        S_LOAD: begin
          if (load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_q <= pend_d;
      idx_q  <= '0;
      amp_q  <= sweep_st.amplitude;
      per_q  <= sweep_st.period;
    end
    if (state_q == S_MOD && div_rsp.done) begin
      scaled_q <= SW'(div_rsp.remainder) * SW'(SINE_ENTRIES);
    end
    if (state_q == S_IDX && div_rsp.done) begin
      idx_q <= div_rsp.quotient[IW-1:0];
    end
    if (state_q == S_MUL) begin
      prod_q <= amp_q * sine_val;
    end
    if (state_q == S_FIN) begin
      pend_q.drive_value <= biased[SPEED_W+14:15];
    end
    if (load) begin
      out_q <= pend_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_record_drives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.record_valid |-> out_q.drive_valid)
    else $error("record without drive command");

  a_clear_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.count_clear && out_q.drive_valid))
    else $error("count clear together with a drive command");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_MOD || state_q == S_IDX))
    else $error("divider finished outside a divide state");

  a_idx_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDX |-> per_q != '0)
    else $error("index division with zero period");

endmodule

`default_nettype wire

### verif/sse_tb_pkg.sv
`timescale 1ns / 1ps
// tick codes and sequencer phase codes shared by the checker and the test top
package sse_tb_pkg;

  import sse_pkg::*;

  localparam logic TICK_SAMPLE     = 1'b0;
  localparam logic TICK_EXPERIMENT = 1'b1;

  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_IDLE    = 2'd1,
    PH_RUNNING = 2'd2
  } run_phase_e;

endpackage

### verif/sse_checker.sv
`timescale 1ns / 1ps
// checker: follows the sweep sequence, predicts each result item and compares it
module sse_checker
  import sse_pkg::*;
  import sse_tb_pkg::*;
#(
  parameter int SINE_ENTRIES = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  sse_in_if    in_mon,
  sse_out_if   out_mon,
  sse_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending_count
);

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int              SHOWN_MAX   = 10;
  localparam int              IW          = $clog2(SINE_ENTRIES);

  logic signed [SPEED_W-1:0] cfg_speed;
  logic [PERIOD_W-1:0]       cfg_period;
  logic [BUDGET_W-1:0]       cfg_budget;

  run_phase_e                run_phase;
  logic signed [SPEED_W-1:0] sweep_amp;
  logic [PERIOD_W-1:0]       sweep_period;
  logic [TIME_W-1:0]         run_t0;
  logic [BUDGET_W-1:0]       ticks_left;

  logic signed [SINE_W-1:0]  sine_q15 [SINE_ENTRIES];
  out_item_t                 expected_q [$];
  int                        shown = 0;

  // quadrant folding plus odd taylor series in q2.30, every product truncated
  initial begin : build_sine
    longint unsigned n, quad, r, x, x2, t, s, v;
    logic signed [SINE_W-1:0] entry;
    n = SINE_ENTRIES;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      quad = (64'd4 * i) / n;
      r    = 64'd4 * i - quad * n;
      if (quad[0]) r = n - r;
      x  = (HALF_PI_Q30 * r) / n;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int m = 5; m >= 1; m--)
        t = Q30_ONE - ((x2 * t) >> 30) / longint'(2 * m * (2 * m + 1));
      s = (x * t) >> 30;
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      entry = v[SINE_W-1:0];
      sine_q15[i] = (quad >= 2) ? -entry : entry;
    end
  end

  function automatic string show_item(input out_item_t o);
    return $sformatf("rec=%0b el=%0d spd=%0d per=%0d cnt=%0d drv=%0b val=%0d clr=%0b",
                     o.record_valid, o.elapsed_ms, o.speed_out, o.period_out,
                     o.count_out, o.drive_valid, o.drive_value, o.count_clear);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    in_item_t          it;
    out_item_t         want, got;
    logic [TIME_W-1:0] elapsed;
    logic [31:0]       rem, idx;
    int                prod;
    int                quo;
    if (!rst_ni) begin
      cfg_speed     = START_SPEED_RST;
      cfg_period    = START_PERIOD_RST;
      cfg_budget    = RUN_BUDGET_RST;
      run_phase     = PH_START;
      sweep_amp     = START_SPEED_RST;
      sweep_period  = START_PERIOD_RST;
      run_t0        = '0;
      ticks_left    = '0;
      expected_q.delete();
      fail_count    = 0;
      pending_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.data.index)
          CFG_START_SPEED:  cfg_speed  = cfg_mon.data.data[SPEED_W-1:0];
          CFG_START_PERIOD: cfg_period = cfg_mon.data.data[PERIOD_W-1:0];
          CFG_RUN_BUDGET:   cfg_budget = cfg_mon.data.data[BUDGET_W-1:0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        it   = in_mon.data;
        want = '0;
        if (it.func == TICK_EXPERIMENT) begin
          if (run_phase == PH_RUNNING) begin
            if (ticks_left == '0) begin
              // budget spent: motor stops
              run_phase        = PH_IDLE;
              want.drive_valid = 1'b1;
            end else begin
              ticks_left = ticks_left - 1'b1;
            end
          end else begin
            if (run_phase == PH_IDLE) begin
              if (sweep_period > PERIOD_STEP) begin
                sweep_period = sweep_period - PERIOD_STEP;
              end else begin
                sweep_period = PERIOD_MAX;
                if (sweep_amp == SPEED_SKIP_LO) sweep_amp = SPEED_SKIP_HI;
                else if (sweep_amp >= SPEED_MAX) sweep_amp = SPEED_MIN;
                else sweep_amp = sweep_amp + SPEED_STEP;
              end
            end else begin
              // start phase and the unused code both load the first run
              sweep_amp    = cfg_speed;
              sweep_period = cfg_period;
            end
            ticks_left       = cfg_budget;
            run_phase        = PH_RUNNING;
            run_t0           = it.now_ms;
            want.count_clear = 1'b1;
          end
        end else if (run_phase == PH_RUNNING) begin
          elapsed = it.now_ms - run_t0;
          idx     = '0;
          if (sweep_period != '0) begin
            rem = elapsed % sweep_period;
            idx = (rem * SINE_ENTRIES) / sweep_period;
          end
          prod              = sweep_amp * sine_q15[idx[IW-1:0]];
          quo               = prod / 32768;
          want.record_valid = 1'b1;
          want.elapsed_ms   = elapsed;
          want.speed_out    = sweep_amp;
          want.period_out   = sweep_period;
          want.count_out    = it.encoder_count;
          want.drive_valid  = 1'b1;
          want.drive_value  = quo[SPEED_W-1:0];
        end
        expected_q.push_back(want);
      end

      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (shown < SHOWN_MAX)
            $display("%0t: result item with nothing expected: %s", $time, show_item(got));
          shown++;
        end else begin
          want = expected_q.pop_front();
          if (got.record_valid !== want.record_valid || got.elapsed_ms !== want.elapsed_ms ||
              got.speed_out !== want.speed_out || got.period_out !== want.period_out ||
              got.count_out !== want.count_out || got.drive_valid !== want.drive_valid ||
              got.drive_value !== want.drive_value || got.count_clear !== want.count_clear)
          begin
            fail_count++;
            if (shown < SHOWN_MAX) begin
              $display("%0t: mismatch", $time);
              $display("  expected %s", show_item(want));
              $display("  actual   %s", show_item(got));
            end
            shown++;
          end
        end
      end
      pending_count = expected_q.size();
    end
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// test top: clock, reset, tick stimulus, register writes, receiver stalls and verdict
module tb;

  import sse_pkg::*;
  import sse_tb_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 100;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int fail_count;
  int pending_count;

  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                hold_reqs     = 0;
  logic [TIME_W-1:0] now_base;

  sse_in_if  in_if ();
  sse_out_if out_if ();
  sse_cfg_if cfg_if ();

  swept_sine_motor_excitation uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  sse_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_mon       (cfg_if),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk_i = ~clk_i;

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: done, errors");
    $finish;
  end

  // result side: random stalls, plus one long hold-off per request
  initial begin : receiver
    int holds_done;
    holds_done   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // valid stays high from one item to the next unless a gap is drawn
  task automatic send_tick(input logic func, input logic [TIME_W-1:0] now,
                           input logic [COUNT_W-1:0] enc);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid              <= 1'b1;
    in_if.data.func          <= func;
    in_if.data.now_ms        <= now;
    in_if.data.encoder_count <= enc;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // mostly steady time with short steps, some big jumps and stray timestamps
  task automatic send_random(input int exp_pct);
    logic              func;
    logic [TIME_W-1:0] now;
    int                pick;
    func = ($urandom_range(99) < exp_pct) ? TICK_EXPERIMENT : TICK_SAMPLE;
    pick = $urandom_range(29);
    if (pick == 0) now_base = now_base + $urandom;
    else now_base = now_base + $urandom_range(2500, 1);
    now = (pick == 1) ? $urandom : now_base;
    send_tick(func, now, $urandom);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] speed, input logic [CFG_DATA_W-1:0] period,
                           input logic [CFG_DATA_W-1:0] budget);
    write_reg(CFG_START_SPEED, speed);
    write_reg(CFG_START_PERIOD, period);
    write_reg(CFG_RUN_BUDGET, budget);
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    wait (pending_count == 0);
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0] quarter_ms [7];
    quarter_ms   = '{32'd0, 32'd2500, 32'd5000, 32'd7500, 32'd9999, 32'd10000, 32'hFFFF_FFFF};
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    now_base     = $urandom;
    send_idle_pct = 18;
    recv_idle_pct = 88;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // first run: amplitude 127 and a period that reads as zero after masking
    configure(16'h5A7F, 16'hC000, 16'hFFF2);

    send_tick(TICK_SAMPLE, 32'd5, 32'd0);
    send_tick(TICK_EXPERIMENT, 32'hFFFF_FF00, 32'h1234_5678);
    send_tick(TICK_SAMPLE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_tick(TICK_SAMPLE, 32'h0000_0100, 32'h8000_0000);
    repeat (3) send_tick(TICK_EXPERIMENT, 32'h0000_0200, 32'hFFFF_FFFF);
    send_tick(TICK_SAMPLE, 32'h0000_0300, 32'd0);
    // wrap from the top amplitude, then the quarter points of a full period
    send_tick(TICK_EXPERIMENT, 32'd1000, 32'd0);
    foreach (quarter_ms[k]) send_tick(TICK_SAMPLE, 32'd1000 + quarter_ms[k], $urandom);
    repeat (3) send_tick(TICK_EXPERIMENT, 32'd20000, $urandom);
    send_tick(TICK_EXPERIMENT, 32'd30000, $urandom);
    send_tick(TICK_SAMPLE, 32'd32250, $urandom);
    repeat (3) send_tick(TICK_EXPERIMENT, 32'd33000, $urandom);
    drain_results();

    // shortest runs so the sweep walks through many amplitudes
    configure(16'h3380, 16'hFFFF, 16'h0000);
    for (int n = 0; n < 700; n++) begin
      if (n == 300) hold_reqs++;
      send_random(50);
    end
    drain_results();

    send_idle_pct = 88;
    recv_idle_pct = 18;
    configure(16'hFF64, 16'h03E8, 16'h000F);
    for (int n = 0; n < 650; n++) begin
      if (n == 325) drain_results();
      send_random(20);
    end
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), {12'($urandom), 4'd1});
    hold_reqs++;
    for (int n = 0; n < 650; n++) send_random(35);
    drain_results();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
